// ===== sv/cpe_pkg.sv =====
// shared types, constants and the step microprogram for the cart-pole integrator
package cpe_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CART_MASS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_MASS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_HALF_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LIMIT = 3'd5;
    localparam int CFG_W = 31;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // quarter-wave sine polynomial, Q30
    localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
    localparam logic signed [31:0] SC1      = 32'sd1686629713;
    localparam logic signed [31:0] SC3      = 32'sd693598668;
    localparam logic signed [31:0] SC5      = 32'sd85569300;
    localparam logic signed [31:0] SC7      = 32'sd5026994;
    localparam logic signed [31:0] SC9      = 32'sd172272;
    // 2^32 / (2*pi), turns per radian
    localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] force_req;
        logic signed [31:0] load_position;
        logic signed [31:0] load_velocity;
        logic signed [31:0] load_angle;
        logic signed [31:0] load_angular_rate;
    } step_item_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] angle;
        logic signed [31:0] angular_rate;
        logic               out_of_bounds;
    } result_item_t;

    typedef enum logic [3:0] {
        OP_MULF,
        OP_MUL30,
        OP_PHASE,
        OP_LOWQ,
        OP_ADD,
        OP_SUB,
        OP_CLAMP,
        OP_SINCOS,
        OP_DIV,
        OP_DIVWB
    } op_t;

    typedef enum logic [4:0] {
        S_X, S_V, S_TH, S_W,
        S_MC, S_MP, S_HL, S_G, S_DT, S_FRC,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
        S_SN, S_CS,
        S_K_TURN, S_K_FOUR3, S_K_RDAMP, S_K_VDAMP,
        S_K_SC1, S_K_SC3, S_K_SC5, S_K_SC7, S_K_SC9, S_K_ONE30
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t a;
        sel_t b;
        sel_t dst;
    } uop_t;

    typedef struct packed {
        logic valid;
        logic capture;
        logic load;
        uop_t uop;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] UCODE_LAST = 6'd55;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX))
            r = S32_MAX;
        else if (v < 64'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'(S32_MAX))
            r = S32_MAX;
        else if (v < 33'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // one step: phase, two quarter sines, then the cart-pole equations
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = '{OP_PHASE, S_TH, S_K_TURN, S_T0};
            6'd1:  u = '{OP_LOWQ, S_T0, S_T0, S_T1};
            6'd2:  u = '{OP_SUB, S_K_ONE30, S_T1, S_T2};
            // sine of x into t3
            6'd3:  u = '{OP_MUL30, S_T1, S_T1, S_T5};
            6'd4:  u = '{OP_MUL30, S_T5, S_K_SC9, S_T6};
            6'd5:  u = '{OP_SUB, S_K_SC7, S_T6, S_T6};
            6'd6:  u = '{OP_MUL30, S_T5, S_T6, S_T6};
            6'd7:  u = '{OP_SUB, S_K_SC5, S_T6, S_T6};
            6'd8:  u = '{OP_MUL30, S_T5, S_T6, S_T6};
            6'd9:  u = '{OP_SUB, S_K_SC3, S_T6, S_T6};
            6'd10: u = '{OP_MUL30, S_T5, S_T6, S_T6};
            6'd11: u = '{OP_SUB, S_K_SC1, S_T6, S_T6};
            6'd12: u = '{OP_MUL30, S_T1, S_T6, S_T6};
            6'd13: u = '{OP_CLAMP, S_T6, S_T6, S_T3};
            // sine of one minus x into t4
            6'd14: u = '{OP_MUL30, S_T2, S_T2, S_T5};
            6'd15: u = '{OP_MUL30, S_T5, S_K_SC9, S_T6};
            6'd16: u = '{OP_SUB, S_K_SC7, S_T6, S_T6};
            6'd17: u = '{OP_MUL30, S_T5, S_T6, S_T6};
            6'd18: u = '{OP_SUB, S_K_SC5, S_T6, S_T6};
            6'd19: u = '{OP_MUL30, S_T5, S_T6, S_T6};
            6'd20: u = '{OP_SUB, S_K_SC3, S_T6, S_T6};
            6'd21: u = '{OP_MUL30, S_T5, S_T6, S_T6};
            6'd22: u = '{OP_SUB, S_K_SC1, S_T6, S_T6};
            6'd23: u = '{OP_MUL30, S_T2, S_T6, S_T6};
            6'd24: u = '{OP_CLAMP, S_T6, S_T6, S_T4};
            6'd25: u = '{OP_SINCOS, S_T3, S_T4, S_SN};
            // t5 total mass, t6 pole mass times half length
            6'd26: u = '{OP_ADD, S_MC, S_MP, S_T5};
            6'd27: u = '{OP_MULF, S_MP, S_HL, S_T6};
            6'd28: u = '{OP_MULF, S_W, S_W, S_T0};
            6'd29: u = '{OP_MULF, S_T6, S_T0, S_T0};
            6'd30: u = '{OP_MUL30, S_T0, S_SN, S_T0};
            6'd31: u = '{OP_ADD, S_FRC, S_T0, S_T0};
            6'd32: u = '{OP_DIV, S_T0, S_T5, S_T3};
            6'd33: u = '{OP_MUL30, S_G, S_SN, S_T1};
            6'd34: u = '{OP_MUL30, S_T3, S_CS, S_T2};
            6'd35: u = '{OP_SUB, S_T1, S_T2, S_T1};
            6'd36: u = '{OP_MUL30, S_CS, S_CS, S_T2};
            6'd37: u = '{OP_MUL30, S_MP, S_T2, S_T2};
            6'd38: u = '{OP_DIV, S_T2, S_T5, S_T2};
            6'd39: u = '{OP_SUB, S_K_FOUR3, S_T2, S_T2};
            6'd40: u = '{OP_MULF, S_HL, S_T2, S_T2};
            6'd41: u = '{OP_DIV, S_T1, S_T2, S_T4};
            6'd42: u = '{OP_MULF, S_T6, S_T4, S_T1};
            6'd43: u = '{OP_MUL30, S_T1, S_CS, S_T1};
            6'd44: u = '{OP_DIV, S_T1, S_T5, S_T1};
            6'd45: u = '{OP_SUB, S_T3, S_T1, S_T1};
            6'd46: u = '{OP_MULF, S_T1, S_DT, S_T1};
            6'd47: u = '{OP_ADD, S_V, S_T1, S_V};
            6'd48: u = '{OP_MULF, S_V, S_DT, S_T1};
            6'd49: u = '{OP_ADD, S_X, S_T1, S_X};
            6'd50: u = '{OP_MULF, S_T4, S_DT, S_T1};
            6'd51: u = '{OP_ADD, S_W, S_T1, S_W};
            6'd52: u = '{OP_MULF, S_W, S_DT, S_T1};
            6'd53: u = '{OP_ADD, S_TH, S_T1, S_TH};
            6'd54: u = '{OP_MULF, S_W, S_K_RDAMP, S_W};
            6'd55: u = '{OP_MULF, S_V, S_K_VDAMP, S_V};
            default: u = '{OP_ADD, S_T0, S_T0, S_T0};
        endcase
        return u;
    endfunction

endpackage

// ===== sv/cpe_div.sv =====
// restoring fixed-point divider, one quotient bit per cycle, saturating
module cpe_div
    import cpe_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    localparam int DW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [DW-1:0] MAG_NEG = {{(DW-32){1'b0}}, 32'h8000_0000};
    localparam logic [DW-1:0] MAG_POS = {{(DW-32){1'b0}}, 32'h7FFF_FFFF};

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      dmag_reg, dmag_next;
    logic             neg_reg, neg_next;
    logic             nneg_reg, nneg_next;
    logic             dzero_reg, dzero_next;

    logic [31:0] nmag;
    logic [32:0] trial;
    logic [32:0] diff;

    assign nmag  = num[31] ? (~num + 32'd1) : num;
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dmag_reg};
    assign done  = busy_reg && (cnt_reg == CNT_W'(DW));

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        nneg_next  = nneg_reg;
        dzero_next = dzero_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            quo_next   = {nmag, {FRAC_BITS{1'b0}}};
            rem_next   = '0;
            dmag_next  = den[31] ? (~den + 32'd1) : den;
            neg_next   = num[31] ^ den[31];
            nneg_next  = !num[31];
            dzero_next = (den == 32'sd0);
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (dzero_reg)
            quot = nneg_reg ? S32_MAX : S32_MIN;
        else if (neg_reg)
            quot = (quo_reg > MAG_NEG) ? S32_MIN : (~quo_reg[31:0] + 32'd1);
        else
            quot = (quo_reg > MAG_POS) ? S32_MAX : quo_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dmag_reg  <= dmag_next;
        neg_reg   <= neg_next;
        nneg_reg  <= nneg_next;
        dzero_reg <= dzero_next;
    end

endmodule

// ===== sv/cpe_dpath.sv =====
// datapath: state, configuration, scratch registers, multiply unit and divider
module cpe_dpath
    import cpe_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  step_item_t           step_item,
    output result_item_t         result_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] PI_Q    = (64'd3373259426 + (64'd1 << (29 - FRAC_BITS)))
                                      >> (30 - FRAC_BITS);
    localparam logic [63:0] FOUR3   = (4 * ONE + 1) / 3;
    localparam logic [63:0] RDAMP   = (997 * ONE + 500) / 1000;
    localparam logic [63:0] VDAMP   = (98 * ONE + 50) / 100;
    localparam logic [63:0] RST_MC  = 4 * ONE;
    localparam logic [63:0] RST_MP  = (2 * ONE + 12) / 25;
    localparam logic [63:0] RST_HL  = 2 * ONE;
    localparam logic [63:0] RST_G   = (49 * ONE + 2) / 5;
    localparam logic [63:0] RST_DT  = (ONE + 25) / 50;
    localparam logic [63:0] RST_LIM = 8 * ONE;

    logic signed [31:0] x_reg, x_next, v_reg, v_next, th_reg, th_next, w_reg, w_next;
    logic [CFG_W-1:0]   mc_reg, mc_next, mp_reg, mp_next, hl_reg, hl_next;
    logic [CFG_W-1:0]   g_reg, g_next, dt_reg, dt_next, lim_reg, lim_next;
    logic signed [31:0] frc_reg, frc_next;
    logic signed [31:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic signed [31:0] t4_reg, t4_next, t5_reg, t5_next, t6_reg, t6_next;
    logic signed [31:0] sn_reg, sn_next, cs_reg, cs_next;
    logic [1:0]         quad_reg, quad_next;

    logic signed [31:0] opa, opb, alu_res, wr_data, div_quot;
    logic signed [63:0] prod;
    logic               wr_en, div_start, div_done;
    logic signed [32:0] xs, lims;

    function automatic logic signed [31:0] pick(
        input sel_t               s,
        input logic signed [31:0] x, v, th, w, frc,
        input logic signed [31:0] t0, t1, t2, t3, t4, t5, t6, sn, cs,
        input logic [CFG_W-1:0]   mc, mp, hl, g, dt
    );
        logic signed [31:0] r;
        unique case (s)
            S_X:       r = x;
            S_V:       r = v;
            S_TH:      r = th;
            S_W:       r = w;
            S_MC:      r = {1'b0, mc};
            S_MP:      r = {1'b0, mp};
            S_HL:      r = {1'b0, hl};
            S_G:       r = {1'b0, g};
            S_DT:      r = {1'b0, dt};
            S_FRC:     r = frc;
            S_T0:      r = t0;
            S_T1:      r = t1;
            S_T2:      r = t2;
            S_T3:      r = t3;
            S_T4:      r = t4;
            S_T5:      r = t5;
            S_T6:      r = t6;
            S_SN:      r = sn;
            S_CS:      r = cs;
            S_K_TURN:  r = TURN_PER_RAD;
            S_K_FOUR3: r = FOUR3[31:0];
            S_K_RDAMP: r = RDAMP[31:0];
            S_K_VDAMP: r = VDAMP[31:0];
            S_K_SC1:   r = SC1;
            S_K_SC3:   r = SC3;
            S_K_SC5:   r = SC5;
            S_K_SC7:   r = SC7;
            S_K_SC9:   r = SC9;
            S_K_ONE30: r = Q30_ONE;
            default:   r = '0;
        endcase
        return r;
    endfunction

    assign opa = pick(cmd.uop.a, x_reg, v_reg, th_reg, w_reg, frc_reg, t0_reg, t1_reg,
                      t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, sn_reg, cs_reg,
                      mc_reg, mp_reg, hl_reg, g_reg, dt_reg);
    assign opb = pick(cmd.uop.b, x_reg, v_reg, th_reg, w_reg, frc_reg, t0_reg, t1_reg,
                      t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, sn_reg, cs_reg,
                      mc_reg, mp_reg, hl_reg, g_reg, dt_reg);

    assign prod = opa * opb;

    always_comb
    begin
        unique case (cmd.uop.op)
            OP_MULF:  alu_res = sat64(prod >>> FRAC_BITS);
            OP_MUL30: alu_res = sat64(prod >>> 30);
            OP_PHASE: alu_res = prod[FRAC_BITS +: 32];
            OP_LOWQ:  alu_res = {2'b00, opa[29:0]};
            OP_ADD:   alu_res = sat33({opa[31], opa} + {opb[31], opb});
            OP_SUB:   alu_res = sat33({opa[31], opa} - {opb[31], opb});
            OP_CLAMP:
            begin
                if (opa > Q30_ONE)
                    alu_res = Q30_ONE;
                else if (opa < 32'sd0)
                    alu_res = '0;
                else
                    alu_res = opa;
            end
            default:  alu_res = '0;
        endcase
    end

    assign div_start = cmd.valid && (cmd.uop.op == OP_DIV);
    assign wr_en     = cmd.valid && (cmd.uop.op != OP_DIV) && (cmd.uop.op != OP_SINCOS);
    assign wr_data   = (cmd.uop.op == OP_DIVWB) ? div_quot : alu_res;

    cpe_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign status.div_done = div_done;

    always_comb
    begin
        x_next    = x_reg;
        v_next    = v_reg;
        th_next   = th_reg;
        w_next    = w_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        hl_next   = hl_reg;
        g_next    = g_reg;
        dt_next   = dt_reg;
        lim_next  = lim_reg;
        frc_next  = frc_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        t2_next   = t2_reg;
        t3_next   = t3_reg;
        t4_next   = t4_reg;
        t5_next   = t5_reg;
        t6_next   = t6_reg;
        sn_next   = sn_reg;
        cs_next   = cs_reg;
        quad_next = quad_reg;

        if (cmd.capture)
        begin
            frc_next = step_item.force_req;
            if (cmd.load)
            begin
                x_next  = step_item.load_position;
                v_next  = step_item.load_velocity;
                th_next = step_item.load_angle;
                w_next  = step_item.load_angular_rate;
            end
        end

        if (wr_en)
        begin
            unique case (cmd.uop.dst)
                S_X:     x_next  = wr_data;
                S_V:     v_next  = wr_data;
                S_TH:    th_next = wr_data;
                S_W:     w_next  = wr_data;
                S_T0:    t0_next = wr_data;
                S_T1:    t1_next = wr_data;
                S_T2:    t2_next = wr_data;
                S_T3:    t3_next = wr_data;
                S_T4:    t4_next = wr_data;
                S_T5:    t5_next = wr_data;
                S_T6:    t6_next = wr_data;
                default: ;
            endcase
        end

        if (cmd.valid && (cmd.uop.op == OP_PHASE))
            quad_next = alu_res[31:30];

        // quadrant picks sign and mirror of the two quarter sines
        if (cmd.valid && (cmd.uop.op == OP_SINCOS))
        begin
            unique case (quad_reg)
                2'd0:
                begin
                    sn_next = opa;
                    cs_next = opb;
                end
                2'd1:
                begin
                    sn_next = opb;
                    cs_next = -opa;
                end
                2'd2:
                begin
                    sn_next = -opa;
                    cs_next = -opb;
                end
                default:
                begin
                    sn_next = -opb;
                    cs_next = opa;
                end
            endcase
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CART_MASS:      mc_next  = cfg_data;
                CFG_POLE_MASS:      mp_next  = cfg_data;
                CFG_POLE_HALF_LEN:  hl_next  = cfg_data;
                CFG_GRAVITY:        g_next   = cfg_data;
                CFG_TIME_STEP:      dt_next  = cfg_data;
                CFG_POSITION_LIMIT: lim_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            v_reg   <= '0;
            th_reg  <= PI_Q[31:0];
            w_reg   <= '0;
            mc_reg  <= RST_MC[CFG_W-1:0];
            mp_reg  <= RST_MP[CFG_W-1:0];
            hl_reg  <= RST_HL[CFG_W-1:0];
            g_reg   <= RST_G[CFG_W-1:0];
            dt_reg  <= RST_DT[CFG_W-1:0];
            lim_reg <= RST_LIM[CFG_W-1:0];
        end
        else
        begin
            x_reg   <= x_next;
            v_reg   <= v_next;
            th_reg  <= th_next;
            w_reg   <= w_next;
            mc_reg  <= mc_next;
            mp_reg  <= mp_next;
            hl_reg  <= hl_next;
            g_reg   <= g_next;
            dt_reg  <= dt_next;
            lim_reg <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frc_reg  <= frc_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        t3_reg   <= t3_next;
        t4_reg   <= t4_next;
        t5_reg   <= t5_next;
        t6_reg   <= t6_next;
        sn_reg   <= sn_next;
        cs_reg   <= cs_next;
        quad_reg <= quad_next;
    end

    assign xs   = {x_reg[31], x_reg};
    assign lims = {2'b00, lim_reg};

    assign result_item.position      = x_reg;
    assign result_item.velocity      = v_reg;
    assign result_item.angle         = th_reg;
    assign result_item.angular_rate  = w_reg;
    assign result_item.out_of_bounds = (xs > lims) || (xs < -lims);

endmodule

// ===== sv/cpe_ctrl.sv =====
// controller: accepts a beat, walks the step microprogram for a step beat, presents the result
module cpe_ctrl
    import cpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_valid,
    input  logic    step_op,
    output logic    step_stall,
    output logic    result_valid,
    input  logic    result_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_DIVW = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    uop_t             uop;

    assign uop          = ucode(pc_reg);
    assign step_stall   = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd        = '0;
        cmd.uop    = uop;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.load    = step_op;
                    pc_next     = '0;
                    state_next  = step_op ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.valid = 1'b1;
                if (uop.op == OP_DIV)
                    state_next = ST_DIVW;
                else if (pc_reg == UCODE_LAST)
                    state_next = ST_OUT;
                else
                    pc_next = pc_reg + PC_W'(1);
            end
            ST_DIVW:
            begin
                // quotient goes to the same destination once the divider finishes
                cmd.uop.op = OP_DIVWB;
                cmd.valid  = status.div_done;
                if (status.div_done)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = ST_RUN;
                end
            end
            ST_OUT:
            begin
                if (!result_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

// ===== sv/cart_pole_euler_step.sv =====
// top level of the cart-pole euler integrator
//
// step channel: step_valid/step_stall with step_item; a beat is taken when
// step_valid is high and step_stall low. operation 0 integrates one euler step
// with force_req, operation 1 loads the four state values unchanged.
// result channel: result_valid/result_stall with result_item carrying the new
// state and the out_of_bounds flag; one result beat per step beat.
// configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// the user must write only while no beat is in flight, the block does not enforce it.
// a load beat shows its result on the next cycle. a step beat walks
// a 56-entry microprogram on one shared 32x32 multiplier, with four divisions
// in a bit-serial divider, before its result is shown.
// one beat is worked at a time: step_stall stays high from accept until the
// result beat is taken, so the next step beat can be taken in the cycle after.
// while result_stall is high the result holds and no new step beat is taken.
// reset: state returns to position 0, velocity 0, angle pi, rate 0, and the
// configuration registers to their default physical constants.
module cart_pole_euler_step
    import cpe_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_valid,
    output logic                 step_stall,
    input  step_item_t           step_item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_item_t         result_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    cpe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_op      (step_item.operation),
        .step_stall   (step_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    cpe_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .step_item   (step_item),
        .result_item (result_item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && !step_stall |=> step_stall)
        else $error("step beat taken while another is in flight");

    a_result_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> step_stall)
        else $error("step channel open while a result is pending");

    a_div_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> cmd.valid && (cmd.uop.op == OP_DIVWB))
        else $error("divider finished without a quotient write");

    a_work_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> step_stall && !result_valid)
        else $error("microprogram running outside a step");

endmodule
